>>> rtl/tma_pkg.sv
// Shared types and constants for the tolerance match allocator.
package tma_pkg;

    localparam int VALUE_W = 30;
    localparam int TOTAL_W = 11;
    localparam logic [TOTAL_W-1:0] MATCH_LIMIT = 11'd1024;

    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [VALUE_W:0]   bound_t;
    typedef logic [VALUE_W:0]   leaf_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_REDUCE,
        ST_APPLY
    } state_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_OFFER = 1'b1
    } op_t;

    typedef struct packed {
        logic compare;
        logic offer;
        logic insert;
        logic remove;
    } cell_cmd_t;

endpackage

>>> rtl/tma_cell.sv
// One cell of the sorted request chain: holds one entry, compares it and shifts it.
module tma_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tma_pkg::cell_cmd_t  cmd,
    input  tma_pkg::value_t     key,
    input  tma_pkg::bound_t     high,
    input  logic [CNT_W-1:0]    count,
    input  tma_pkg::value_t     left_value,
    input  logic                left_flag,
    input  tma_pkg::value_t     right_value,
    output tma_pkg::value_t     value,
    output logic                flag,
    output tma_pkg::leaf_t      leaf
);

    tma_pkg::value_t value_reg;
    tma_pkg::value_t value_next;
    logic            flag_reg;
    logic            flag_next;
    logic            in_use;
    logic            hit;

    always_comb
    begin
        in_use = count > CNT_W'(IDX);

        flag_next = flag_reg;
        if (cmd.compare)
        begin
            if (cmd.offer)
            begin
                flag_next = !in_use || (value_reg >= key);
            end
            else
            begin
                flag_next = !in_use || (value_reg > key);
            end
        end

        value_next = value_reg;
        if (cmd.insert && flag_reg)
        begin
            value_next = left_flag ? left_value : key;
        end
        else if (cmd.remove && flag_reg)
        begin
            value_next = right_value;
        end

        hit  = flag_reg && !left_flag && in_use && ({1'b0, value_reg} <= high);
        leaf = {hit, hit ? value_reg : tma_pkg::value_t'(0)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else
        begin
            flag_reg <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign flag  = flag_reg;

endmodule

>>> rtl/tma_or_tree.sv
// Registered binary OR tree that collects the single candidate hit of the chain.
module tma_or_tree #(
    parameter int LEVELS = 10,
    parameter int WIDTH  = 31
) (
    input  logic             clk,
    input  logic [WIDTH-1:0] leaves [2**LEVELS],
    output logic [WIDTH-1:0] root
);

    localparam int INNER = 2**LEVELS - 1;
    localparam int NODES = 2**(LEVELS+1) - 1;

    logic [WIDTH-1:0] node_w   [NODES];
    logic [WIDTH-1:0] node_reg [INNER];

    for (genvar l = 0; l < 2**LEVELS; l++)
    begin : g_leaf
        assign node_w[INNER+l] = leaves[l];
    end

    for (genvar n = 0; n < INNER; n++)
    begin : g_node
        always_ff @(posedge clk)
        begin
            node_reg[n] <= node_w[2*n+1] | node_w[2*n+2];
        end
        assign node_w[n] = node_reg[n];
    end

    assign root = node_w[0];

endmodule

>>> rtl/tolerance_match_allocator.sv
// A load steps through the compare and apply states, an offer through compare, reduce and apply;
// done is registered from the apply state. A new start is taken only while idle. An offer waits
// in the reduce state while the registered OR tree gathers the candidate from the cell chain.
// Each result is shown for one cycle with done; the receiver cannot stall.
// Reset (rst_n, asynchronous, active low) empties the store and clears the entry count, the match counter and
// the tolerance; entry contents are not cleared and no clearing pass is needed.
module tolerance_match_allocator #(
    parameter int CAPACITY = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        op,
    input  logic [tma_pkg::VALUE_W-1:0] size_value,
    input  logic                        tolerance_we,
    input  logic [tma_pkg::VALUE_W-1:0] tolerance_wdata,
    output logic                        done,
    output logic                        matched,
    output logic [tma_pkg::VALUE_W-1:0] matched_request,
    output logic [tma_pkg::TOTAL_W-1:0] match_total,
    output logic                        store_full
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LEVELS = $clog2(CAPACITY);
    localparam int LEAVES = 2**LEVELS;
    localparam int RED_W  = $clog2(LEVELS + 1);

    tma_pkg::state_t    state_reg;
    tma_pkg::state_t    state_next;
    logic [RED_W-1:0]   red_cnt_reg;
    logic [RED_W-1:0]   red_cnt_next;
    tma_pkg::value_t    tolerance_reg;
    tma_pkg::value_t    tolerance_next;
    logic               op_reg;
    logic               op_next;
    tma_pkg::value_t    key_reg;
    tma_pkg::value_t    key_next;
    tma_pkg::bound_t    high_reg;
    tma_pkg::bound_t    high_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [tma_pkg::TOTAL_W-1:0] match_counter_reg;
    logic [tma_pkg::TOTAL_W-1:0] match_counter_next;

    logic               done_reg;
    logic               done_next;
    logic               matched_reg;
    logic               matched_next;
    tma_pkg::value_t    matched_request_reg;
    tma_pkg::value_t    matched_request_next;
    logic [tma_pkg::TOTAL_W-1:0] match_total_reg;
    logic [tma_pkg::TOTAL_W-1:0] match_total_next;
    logic               store_full_reg;
    logic               store_full_next;

    tma_pkg::cell_cmd_t cmd;
    logic               accept;
    logic               full;
    logic               root_hit;
    tma_pkg::leaf_t     root;
    tma_pkg::value_t    low_bound;

    tma_pkg::value_t    cell_value [CAPACITY];
    logic               cell_flag  [CAPACITY];
    tma_pkg::leaf_t     cell_leaf  [CAPACITY];
    tma_pkg::leaf_t     tree_leaf  [LEAVES];

    assign accept   = start && (state_reg == tma_pkg::ST_IDLE);
    assign full     = count_reg == CNT_W'(CAPACITY);
    assign root_hit = root[tma_pkg::VALUE_W];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        tma_pkg::value_t left_value;
        logic            left_flag;
        tma_pkg::value_t right_value;

        if (i == 0)
        begin : g_first
            assign left_value = '0;
            assign left_flag  = 1'b0;
        end
        else
        begin : g_inner
            assign left_value = cell_value[i-1];
            assign left_flag  = cell_flag[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = '0;
        end
        else
        begin : g_body
            assign right_value = cell_value[i+1];
        end

        tma_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .key         (key_reg),
            .high        (high_reg),
            .count       (count_reg),
            .left_value  (left_value),
            .left_flag   (left_flag),
            .right_value (right_value),
            .value       (cell_value[i]),
            .flag        (cell_flag[i]),
            .leaf        (cell_leaf[i])
        );
    end

    for (genvar l = 0; l < LEAVES; l++)
    begin : g_pad
        if (l < CAPACITY)
        begin : g_used
            assign tree_leaf[l] = cell_leaf[l];
        end
        else
        begin : g_unused
            assign tree_leaf[l] = '0;
        end
    end

    tma_or_tree #(
        .LEVELS (LEVELS),
        .WIDTH  (tma_pkg::VALUE_W + 1)
    ) u_tree (
        .clk    (clk),
        .leaves (tree_leaf),
        .root   (root)
    );

    always_comb
    begin
        state_next   = state_reg;
        red_cnt_next = red_cnt_reg;
        unique case (state_reg)
            tma_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = tma_pkg::ST_COMPARE;
                end
            end
            tma_pkg::ST_COMPARE:
            begin
                red_cnt_next = '0;
                state_next   = (op_reg == tma_pkg::OP_OFFER) ? tma_pkg::ST_REDUCE
                                                             : tma_pkg::ST_APPLY;
            end
            tma_pkg::ST_REDUCE:
            begin
                red_cnt_next = red_cnt_reg + 1'b1;
                if (red_cnt_reg == RED_W'(LEVELS - 1))
                begin
                    state_next = tma_pkg::ST_APPLY;
                end
            end
            tma_pkg::ST_APPLY:
            begin
                state_next = tma_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tma_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = state_reg != tma_pkg::ST_IDLE;
        unique case (state_reg)
            tma_pkg::ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                cmd.offer   = op_reg == tma_pkg::OP_OFFER;
            end
            tma_pkg::ST_APPLY:
            begin
                cmd.insert = (op_reg == tma_pkg::OP_LOAD) && !full;
                cmd.remove = (op_reg == tma_pkg::OP_OFFER) && root_hit;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        tolerance_next = tolerance_wdata;
        if (!tolerance_we)
        begin
            tolerance_next = tolerance_reg;
        end

        low_bound = (size_value >= tolerance_reg) ? size_value - tolerance_reg : '0;

        op_next   = op_reg;
        key_next  = key_reg;
        high_next = high_reg;
        if (accept)
        begin
            op_next   = op;
            key_next  = (op == tma_pkg::OP_OFFER) ? low_bound : size_value;
            high_next = {1'b0, size_value} + {1'b0, tolerance_reg};
        end

        count_next         = count_reg;
        match_counter_next = match_counter_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.remove)
        begin
            count_next = count_reg - 1'b1;
            if (match_counter_reg < tma_pkg::MATCH_LIMIT)
            begin
                match_counter_next = match_counter_reg + 1'b1;
            end
        end

        done_next            = state_reg == tma_pkg::ST_APPLY;
        matched_next         = matched_reg;
        matched_request_next = matched_request_reg;
        match_total_next     = match_total_reg;
        store_full_next      = store_full_reg;
        if (state_reg == tma_pkg::ST_APPLY)
        begin
            matched_next         = cmd.remove;
            matched_request_next = cmd.remove ? root[tma_pkg::VALUE_W-1:0] : '0;
            match_total_next     = match_counter_next;
            store_full_next      = (op_reg == tma_pkg::OP_LOAD) && full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= tma_pkg::ST_IDLE;
            red_cnt_reg       <= '0;
            tolerance_reg     <= '0;
            count_reg         <= '0;
            match_counter_reg <= '0;
            op_reg            <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            red_cnt_reg       <= red_cnt_next;
            tolerance_reg     <= tolerance_next;
            count_reg         <= count_next;
            match_counter_reg <= match_counter_next;
            op_reg            <= op_next;
            done_reg          <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg             <= key_next;
        high_reg            <= high_next;
        matched_reg         <= matched_next;
        matched_request_reg <= matched_request_next;
        match_total_reg     <= match_total_next;
        store_full_reg      <= store_full_next;
    end

    assign done            = done_reg;
    assign matched         = matched_reg;
    assign matched_request = matched_request_reg;
    assign match_total     = match_total_reg;
    assign store_full      = store_full_reg;

endmodule

>>> test/tb_tolerance_match_allocator.sv
`timescale 1ns / 100ps
// Self-checking testbench for the tolerance match allocator: directed table, then random phases.
module tb_tolerance_match_allocator;

    typedef struct packed {
        logic                                matched;
        tma_pkg::value_t                     request;
        logic [tma_pkg::TOTAL_W-1:0]         total;
        logic                                full;
    } alloc_result_t;

    typedef struct packed {
        logic            is_cfg;
        tma_pkg::op_t    kind;
        tma_pkg::value_t value;
        logic            typed;
        alloc_result_t   want;
    } stim_row_t;

    localparam tma_pkg::value_t SIZE_MAX = '1;
    localparam int STORE_DEPTH = 1024;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_LIMIT = 10;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic                        op;
    tma_pkg::value_t             size_value;
    logic                        tolerance_we;
    tma_pkg::value_t             tolerance_wdata;
    logic                        done;
    logic                        matched;
    tma_pkg::value_t             matched_request;
    logic [tma_pkg::TOTAL_W-1:0] match_total;
    logic                        store_full;

    tma_pkg::value_t             held_requests[$];
    tma_pkg::value_t             model_tolerance;
    logic [tma_pkg::TOTAL_W-1:0] match_count;
    alloc_result_t               pending_results[$];
    stim_row_t                   directed_rows[$];
    alloc_result_t               oldest_result;
    alloc_result_t               seen_result;
    int                          error_count = 0;
    int                          idle_cycles = 0;
    logic                        allow_gaps = 1'b1;

    tolerance_match_allocator dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .size_value      (size_value),
        .tolerance_we    (tolerance_we),
        .tolerance_wdata (tolerance_wdata),
        .done            (done),
        .matched         (matched),
        .matched_request (matched_request),
        .match_total     (match_total),
        .store_full      (store_full)
    );

    always #1 clk = ~clk;

    function automatic alloc_result_t pack_result(input logic m, input tma_pkg::value_t req,
                                                  input int total, input logic full);
        alloc_result_t r;
        r.matched = m;
        r.request = req;
        r.total = total[tma_pkg::TOTAL_W-1:0];
        r.full = full;
        return r;
    endfunction

    function automatic stim_row_t item_row(input tma_pkg::op_t kind,
                                           input tma_pkg::value_t value);
        stim_row_t r;
        r = '0;
        r.kind = kind;
        r.value = value;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input tma_pkg::op_t kind,
                                            input tma_pkg::value_t value,
                                            input alloc_result_t want);
        stim_row_t r;
        r = item_row(kind, value);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input tma_pkg::value_t value);
        stim_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.value = value;
        return r;
    endfunction

    function automatic alloc_result_t predict_allocation(input tma_pkg::op_t kind,
                                                         input tma_pkg::value_t value);
        alloc_result_t   r;
        tma_pkg::bound_t low;
        tma_pkg::bound_t high;
        int              pos;
        r = '0;
        pos = 0;
        if (kind == tma_pkg::OP_LOAD)
        begin
            if (held_requests.size() >= STORE_DEPTH)
            begin
                r.full = 1'b1;
            end
            else
            begin
                while (pos < held_requests.size() && held_requests[pos] <= value) pos++;
                held_requests.insert(pos, value);
            end
        end
        else
        begin
            low = (value >= model_tolerance) ? {1'b0, value - model_tolerance} : '0;
            high = {1'b0, value} + {1'b0, model_tolerance};
            while (pos < held_requests.size() && {1'b0, held_requests[pos]} < low) pos++;
            if (pos < held_requests.size() && {1'b0, held_requests[pos]} <= high)
            begin
                r.matched = 1'b1;
                r.request = held_requests[pos];
                held_requests.delete(pos);
                if (match_count < tma_pkg::MATCH_LIMIT) match_count++;
            end
        end
        r.total = match_count;
        return r;
    endfunction

    task automatic drive_transaction(input tma_pkg::op_t kind, input tma_pkg::value_t value,
                                     input logic typed, input alloc_result_t want);
        alloc_result_t predicted;
        while (allow_gaps && $urandom_range(99) < 21)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        op <= kind;
        size_value <= value;
        @(posedge clk);
        while (busy) @(posedge clk);
        predicted = predict_allocation(kind, value);
        pending_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic send_request(input tma_pkg::op_t kind, input tma_pkg::value_t value);
        drive_transaction(kind, value, 1'b0, '0);
    endtask

    task automatic set_tolerance(input tma_pkg::value_t value);
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        tolerance_we <= 1'b1;
        tolerance_wdata <= value;
        model_tolerance = value;
        @(negedge clk);
        tolerance_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done) idle_cycles = 0;
            else idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            if (done)
            begin
                seen_result = {matched, matched_request, match_total, store_full};
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("unexpected transaction: matched=%0d request=%0h %s",
                                 matched, matched_request,
                                 $sformatf("total=%0d full=%0d", match_total, store_full));
                end
                else
                begin
                    oldest_result = pending_results.pop_front();
                    if (seen_result !== oldest_result)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("mismatch: expected %0d/%0h/%0d/%0d, got %0d/%0h/%0d/%0d",
                                     oldest_result.matched, oldest_result.request,
                                     oldest_result.total, oldest_result.full,
                                     matched, matched_request, match_total, store_full);
                    end
                end
            end
        end
    end

    initial
    begin
        tma_pkg::value_t cursor;
        int              pick;

        rst_n = 1'b0;
        start = 1'b0;
        op = tma_pkg::OP_LOAD;
        size_value = '0;
        tolerance_we = 1'b0;
        tolerance_wdata = '0;
        model_tolerance = '0;
        match_count = '0;

        directed_rows.push_back(typed_row(tma_pkg::OP_OFFER, '0, pack_result(0, '0, 0, 0)));
        directed_rows.push_back(typed_row(tma_pkg::OP_OFFER, SIZE_MAX,
                                          pack_result(0, '0, 0, 0)));
        directed_rows.push_back(typed_row(tma_pkg::OP_LOAD, SIZE_MAX,
                                          pack_result(0, '0, 0, 0)));
        directed_rows.push_back(typed_row(tma_pkg::OP_LOAD, '0, pack_result(0, '0, 0, 0)));
        directed_rows.push_back(typed_row(tma_pkg::OP_OFFER, '0, pack_result(1, '0, 1, 0)));
        directed_rows.push_back(item_row(tma_pkg::OP_OFFER, 30'd1));
        directed_rows.push_back(typed_row(tma_pkg::OP_OFFER, SIZE_MAX,
                                          pack_result(1, SIZE_MAX, 2, 0)));
        directed_rows.push_back(cfg_row(30'd5));
        directed_rows.push_back(item_row(tma_pkg::OP_LOAD, 30'd10));
        directed_rows.push_back(item_row(tma_pkg::OP_LOAD, 30'd10));
        directed_rows.push_back(item_row(tma_pkg::OP_OFFER, 30'd3));
        directed_rows.push_back(item_row(tma_pkg::OP_LOAD, 30'd4));
        directed_rows.push_back(item_row(tma_pkg::OP_OFFER, 30'd3));
        directed_rows.push_back(item_row(tma_pkg::OP_OFFER, 30'd7));
        directed_rows.push_back(item_row(tma_pkg::OP_OFFER, 30'd15));
        directed_rows.push_back(item_row(tma_pkg::OP_OFFER, 30'd20));
        directed_rows.push_back(cfg_row(SIZE_MAX));
        directed_rows.push_back(item_row(tma_pkg::OP_LOAD, 30'd1000));
        directed_rows.push_back(item_row(tma_pkg::OP_OFFER, '0));
        directed_rows.push_back(item_row(tma_pkg::OP_LOAD, SIZE_MAX));
        directed_rows.push_back(item_row(tma_pkg::OP_OFFER, 30'd5));
        directed_rows.push_back(item_row(tma_pkg::OP_LOAD, 30'h2AAAAAAA));
        directed_rows.push_back(item_row(tma_pkg::OP_OFFER, SIZE_MAX));
        directed_rows.push_back(cfg_row('0));
        directed_rows.push_back(item_row(tma_pkg::OP_LOAD, 30'h15555555));
        directed_rows.push_back(item_row(tma_pkg::OP_OFFER, 30'h15555555));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                set_tolerance(directed_rows[i].value);
            else
                drive_transaction(directed_rows[i].kind, directed_rows[i].value,
                                  directed_rows[i].typed, directed_rows[i].want);
        end

        set_tolerance(tma_pkg::value_t'($urandom_range(0, 64)));
        cursor = '0;
        for (int i = 0; i < 120; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                send_request(tma_pkg::op_t'($urandom_range(1)), tma_pkg::value_t'($urandom));
            end
            else if (pick < 55)
            begin
                send_request(tma_pkg::OP_LOAD,
                             cursor + tma_pkg::value_t'($urandom_range(0, 200)));
            end
            else
            begin
                cursor = cursor + tma_pkg::value_t'($urandom_range(0, 40));
                send_request(tma_pkg::OP_OFFER, cursor);
            end
        end

        set_tolerance('0);
        for (int i = 0; i < 80; i++)
            send_request(tma_pkg::op_t'($urandom_range(1)),
                         tma_pkg::value_t'($urandom_range(0, 31)));

        set_tolerance(tma_pkg::value_t'($urandom));
        for (int i = 0; i < 60; i++)
            send_request(tma_pkg::op_t'($urandom_range(1)), tma_pkg::value_t'($urandom));

        set_tolerance(SIZE_MAX);
        for (int i = 0; i < 1030; i++)
        begin
            allow_gaps = (i >= 300);
            send_request(tma_pkg::OP_LOAD, tma_pkg::value_t'($urandom));
        end
        for (int i = 0; i < 40; i++)
            send_request(tma_pkg::OP_OFFER, tma_pkg::value_t'($urandom));

        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
rtl/tma_pkg.sv
rtl/tma_cell.sv
rtl/tma_or_tree.sv
rtl/tolerance_match_allocator.sv
test/tb_tolerance_match_allocator.sv
